[rtl/pulse_peak_rate_meter_unit_macros.svh]
// Assertion macros shared by the pulse rate meter RTL.
`ifndef PULSE_PEAK_RATE_METER_UNIT_MACROS_SVH
`define PULSE_PEAK_RATE_METER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Flag a condition that must never hold outside reset.
`define PPRM_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");

// Require b in the same cycle whenever a holds outside reset.
`define PPRM_ASSERT_IMPLY(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

`else

`define PPRM_ASSERT_NEVER(lbl, clk, rst, cond)
`define PPRM_ASSERT_IMPLY(lbl, clk, rst, a, b)

`endif

`endif

[rtl/pprm_pkg.sv]
// Shared types and constants of the pulse rate meter.
package pprm_pkg;

   localparam int SAMPLE_BITS   = 10;
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int COUNT_BITS    = 8;
   localparam int RATE_BITS     = 8;
   localparam int SPAN_BITS     = 2 * COUNT_BITS;
   localparam int STEP_BITS     = $clog2(SPAN_BITS);
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;

   localparam logic [SPAN_BITS-1:0]   MS_PER_MINUTE = SPAN_BITS'(60000);
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX     = '1;
   localparam logic [RATE_BITS-1:0]   RATE_MAX      = '1;

   localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET    = SAMPLE_BITS'(400);
   localparam logic [COUNT_BITS-1:0]  RISE_LIMIT_RESET   = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0]  FALL_LIMIT_RESET   = COUNT_BITS'(2);
   localparam logic [COUNT_BITS-1:0]  SEARCH_LIMIT_RESET = COUNT_BITS'(255);
   localparam logic [COUNT_BITS-1:0]  PERIOD_RESET       = COUNT_BITS'(20);

   // Register word index (byte address / 4)
   typedef enum logic [2:0] {
      CSR_PEAK_THRESHOLD = 3'd0,
      CSR_RISE_LIMIT     = 3'd1,
      CSR_FALL_LIMIT     = 3'd2,
      CSR_SEARCH_LIMIT   = 3'd3,
      CSR_SAMPLE_PERIOD  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [SPAN_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [SPAN_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

[rtl/pprm_div.sv]
// Bit-serial restoring divider: one minute in ms divided by the peak span.
module pprm_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pprm_pkg::div_req_type div_req,
   output pprm_pkg::div_rsp_type div_rsp
);
   import pprm_pkg::*;

   logic                 busy_ff, busy_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [SPAN_BITS-1:0] divisor_ff, divisor_in;
   logic [SPAN_BITS-1:0] rem_ff, rem_in;
   logic [SPAN_BITS-1:0] quot_ff, quot_in;
   logic                 done_ff, done_in;
   logic [SPAN_BITS:0]   rem_shift;
   logic [SPAN_BITS+1:0] diff;
   logic                 fits;

   // Shift in the next dividend bit and try one subtract
   assign rem_shift = {rem_ff, MS_PER_MINUTE[step_ff]};
   assign diff      = {1'b0, rem_shift} - {2'b00, divisor_ff};
   assign fits      = ~diff[SPAN_BITS+1];

   always_comb begin
      busy_in    = busy_ff;
      step_in    = step_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = STEP_BITS'(SPAN_BITS - 1);
         divisor_in = div_req.divisor;
         rem_in     = '0;
         quot_in    = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[SPAN_BITS-1:0] : rem_shift[SPAN_BITS-1:0];
         quot_in = {quot_ff[SPAN_BITS-2:0], fits};
         step_in = step_ff - STEP_BITS'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

[rtl/pulse_peak_rate_meter_unit.sv]
// Pulse rate meter: peak detector, interval timer and rate divider.
// A word that ends no measurement passes the accept and update states; a timeout word
// goes from update to the result state. A rate word runs the serial divider, one
// quotient bit a cycle, before its result shows in the result state.
// Synchronous active-high reset restores register defaults and the search state;
// no clearing pass is needed.
`include "pulse_peak_rate_meter_unit_macros.svh"

module pulse_peak_rate_meter_unit (
   input  logic                                clock,
   input  logic                                reset,
   // sample in [9:0], zero padding above
   input  logic [pprm_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // beats_per_minute in [7:0]
   output logic [pprm_pkg::RATE_BITS-1:0]      rsp_tdata,
   // rate_found in [0]
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pprm_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [pprm_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [pprm_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import pprm_pkg::*;

   // Configuration registers
   logic [SAMPLE_BITS-1:0] threshold_ff;
   logic [COUNT_BITS-1:0]  rise_limit_ff, fall_limit_ff, search_limit_ff, period_ff;
   logic                   csr_write;
   csr_index_type          csr_index;

   // Search state
   state_type              state_ff, state_in;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic                   second_ff, second_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [COUNT_BITS-1:0]  rise_ff, rise_in;
   logic [COUNT_BITS-1:0]  fall_ff, fall_in;
   logic [COUNT_BITS-1:0]  left_ff, left_in;
   logic [COUNT_BITS-1:0]  interval_ff, interval_in;

   // Result register
   logic [RATE_BITS-1:0]   bpm_ff, bpm_in;
   logic                   found_ff, found_in;
   logic                   valid_ff;

   // Update decode
   logic [COUNT_BITS-1:0]  interval_step, rise_step, fall_step;
   logic [SAMPLE_BITS-1:0] max_step;
   logic                   peak, timeout;
   logic                   accept, go_divide, go_timeout, load_rate;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THRESHOLD_RESET;
         rise_limit_ff   <= RISE_LIMIT_RESET;
         fall_limit_ff   <= FALL_LIMIT_RESET;
         search_limit_ff <= SEARCH_LIMIT_RESET;
         period_ff       <= PERIOD_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PEAK_THRESHOLD: threshold_ff    <= csr_pwdata[SAMPLE_BITS-1:0];
            CSR_RISE_LIMIT:     rise_limit_ff   <= csr_pwdata[COUNT_BITS-1:0];
            CSR_FALL_LIMIT:     fall_limit_ff   <= csr_pwdata[COUNT_BITS-1:0];
            CSR_SEARCH_LIMIT:   search_limit_ff <= csr_pwdata[COUNT_BITS-1:0];
            CSR_SAMPLE_PERIOD:  period_ff       <= csr_pwdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_PEAK_THRESHOLD:
            csr_prdata = {{(CSR_DATA_BITS-SAMPLE_BITS){1'b0}}, threshold_ff};
         CSR_RISE_LIMIT:
            csr_prdata = {{(CSR_DATA_BITS-COUNT_BITS){1'b0}}, rise_limit_ff};
         CSR_FALL_LIMIT:
            csr_prdata = {{(CSR_DATA_BITS-COUNT_BITS){1'b0}}, fall_limit_ff};
         CSR_SEARCH_LIMIT:
            csr_prdata = {{(CSR_DATA_BITS-COUNT_BITS){1'b0}}, search_limit_ff};
         CSR_SAMPLE_PERIOD:
            csr_prdata = {{(CSR_DATA_BITS-COUNT_BITS){1'b0}}, period_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   // Peak detector step on the held sample
   always_comb begin
      interval_step = interval_ff;
      if (second_ff && interval_ff != COUNT_MAX) begin
         interval_step = interval_ff + COUNT_BITS'(1);
      end
      max_step  = max_ff;
      rise_step = rise_ff;
      fall_step = fall_ff;
      if (sample_ff >= threshold_ff) begin
         if (sample_ff > max_ff) begin
            max_step  = sample_ff;
            fall_step = '0;
            if (rise_ff != COUNT_MAX) begin
               rise_step = rise_ff + COUNT_BITS'(1);
            end
         end else if (fall_ff != COUNT_MAX) begin
            fall_step = fall_ff + COUNT_BITS'(1);
         end
      end
   end

   assign peak       = (rise_step > rise_limit_ff) && (fall_step > fall_limit_ff);
   assign timeout    = !peak && (left_ff <= COUNT_BITS'(1));
   assign go_divide  = (state_ff == ST_UPDATE) && peak && second_ff;
   assign go_timeout = (state_ff == ST_UPDATE) && timeout;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (go_divide) begin
               state_in = ST_DIVIDE;
            end else if (go_timeout) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: if (div_rsp.done) state_in = ST_RESULT;
         ST_RESULT: if (rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // State machine outputs
   always_comb begin
      req_tready      = 1'b0;
      div_req.start   = 1'b0;
      div_req.divisor = SPAN_BITS'(interval_step) * SPAN_BITS'(period_ff);
      load_rate       = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_tready    = 1'b1;
         ST_UPDATE: div_req.start = go_divide;
         ST_DIVIDE: load_rate     = div_rsp.done;
         ST_RESULT: ;
         default:   ;
      endcase
   end

   assign accept = req_tvalid & req_tready;

   // Search registers: advance, restart after a peak or timeout
   always_comb begin
      second_in   = second_ff;
      max_in      = max_ff;
      rise_in     = rise_ff;
      fall_in     = fall_ff;
      left_in     = left_ff;
      interval_in = interval_ff;
      if (state_ff == ST_UPDATE) begin
         if (peak || timeout) begin
            second_in   = peak && !second_ff;
            interval_in = '0;
            max_in      = '0;
            rise_in     = '0;
            fall_in     = '0;
            left_in     = search_limit_ff;
         end else begin
            interval_in = interval_step;
            max_in      = max_step;
            rise_in     = rise_step;
            fall_in     = fall_step;
            left_in     = left_ff - COUNT_BITS'(1);
         end
      end
   end

   // Result word: saturate the quotient, zero on timeout
   always_comb begin
      bpm_in   = bpm_ff;
      found_in = found_ff;
      if (go_timeout) begin
         bpm_in   = '0;
         found_in = 1'b0;
      end else if (load_rate) begin
         found_in = 1'b1;
         if (div_rsp.quotient > SPAN_BITS'(RATE_MAX)) begin
            bpm_in = RATE_MAX;
         end else begin
            bpm_in = div_rsp.quotient[RATE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         second_ff   <= 1'b0;
         max_ff      <= '0;
         rise_ff     <= '0;
         fall_ff     <= '0;
         left_ff     <= SEARCH_LIMIT_RESET;
         interval_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         second_ff   <= second_in;
         max_ff      <= max_in;
         rise_ff     <= rise_in;
         fall_ff     <= fall_in;
         left_ff     <= left_in;
         interval_ff <= interval_in;
         valid_ff    <= (state_in == ST_RESULT);
      end
      if (accept) begin
         sample_ff <= req_tdata[SAMPLE_BITS-1:0];
      end
      bpm_ff   <= bpm_in;
      found_ff <= found_in;
   end

   assign rsp_tdata  = bpm_ff;
   assign rsp_tuser  = found_ff;
   assign rsp_tvalid = valid_ff;

   pprm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Checks
   `PPRM_ASSERT_NEVER(a_ready_while_result, clock, reset, req_tready && rsp_tvalid)
   `PPRM_ASSERT_IMPLY(a_div_only_in_divide, clock, reset, div_rsp.busy, state_ff == ST_DIVIDE)
   `PPRM_ASSERT_IMPLY(a_timeout_zero_rate, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)

endmodule

[sim/tb_pulse_peak_rate_meter_unit.sv]
// Self-checking testbench for the pulse rate meter: sample stream in, rate words out.
module tb_pulse_peak_rate_meter_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import pprm_pkg::*;

   localparam int          SETTLE_CYCLES = 32;
   localparam int          HOLD_CYCLES   = 500;
   localparam int          PHASE_COUNT   = 14;
   localparam int          PHASE_ITEMS   = 120;
   localparam int          HOLD_PHASE    = 2;
   localparam int          STEADY_PHASE  = 5;
   localparam int          SLOW_PHASE    = 9;
   localparam logic [2:0]  CSR_SPARE_LOW = 3'd5;
   localparam logic [2:0]  CSR_SPARE_TOP = 3'd7;

   typedef struct packed {
      logic [RATE_BITS-1:0] bpm;
      logic                 found;
   } rate_reading_type;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [2:0]       index;
      logic [31:0]      value;
      logic             typed;
      rate_reading_type reading;
   } plan_row_type;

   logic                      clock;
   logic                      reset;
   logic [REQ_DATA_BITS-1:0]  req_tdata;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [RATE_BITS-1:0]      rsp_tdata;
   logic                      rsp_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;

   // Register copies
   logic [SAMPLE_BITS-1:0] cfg_threshold;
   logic [COUNT_BITS-1:0]  cfg_rise_limit;
   logic [COUNT_BITS-1:0]  cfg_fall_limit;
   logic [COUNT_BITS-1:0]  cfg_search_limit;
   logic [COUNT_BITS-1:0]  cfg_period;

   // Peak search state
   logic                   meter_second;
   logic [SAMPLE_BITS-1:0] meter_max;
   logic [COUNT_BITS-1:0]  meter_rises;
   logic [COUNT_BITS-1:0]  meter_falls;
   logic [COUNT_BITS-1:0]  meter_left;
   logic [COUNT_BITS-1:0]  meter_interval;

   rate_reading_type expected_rates [$];
   plan_row_type     directed_plan [$];
   int unsigned      error_count;
   int unsigned      samples_sent;
   bit               idle_on;
   bit               hold_request;

   pulse_peak_rate_meter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Begin a fresh peak search with the current limit
   function automatic void restart_search();
      meter_max   = '0;
      meter_rises = '0;
      meter_falls = '0;
      meter_left  = cfg_search_limit;
   endfunction

   // Advance the meter by one sample; return 1 when a rate word is due
   function automatic bit predict_measurement(input logic [SAMPLE_BITS-1:0] s,
                                              output rate_reading_type reading);
      int unsigned span;
      int unsigned quotient;
      reading = '0;
      if (meter_second && meter_interval < COUNT_MAX) meter_interval++;
      if (s >= cfg_threshold) begin
         if (s > meter_max) begin
            meter_max = s;
            if (meter_rises < COUNT_MAX) meter_rises++;
            meter_falls = '0;
         end else if (meter_falls < COUNT_MAX) begin
            meter_falls++;
         end
      end
      // Peak confirmed: first one opens the interval, second one closes it
      if (meter_rises > cfg_rise_limit && meter_falls > cfg_fall_limit) begin
         restart_search();
         if (!meter_second) begin
            meter_second   = 1'b1;
            meter_interval = '0;
            return 1'b0;
         end
         span = int'(meter_interval) * int'(cfg_period);
         if (span == 0) begin
            reading.bpm = RATE_MAX;
         end else begin
            quotient    = int'(MS_PER_MINUTE) / span;
            reading.bpm = (quotient > int'(RATE_MAX)) ? RATE_MAX : RATE_BITS'(quotient);
         end
         reading.found  = 1'b1;
         meter_second   = 1'b0;
         meter_interval = '0;
         return 1'b1;
      end
      // Timeout ends the measurement
      if (meter_left <= 1) begin
         meter_second   = 1'b0;
         meter_interval = '0;
         restart_search();
         return 1'b1;
      end
      meter_left--;
      return 1'b0;
   endfunction

   // Offer one sample word, wait for acceptance, then record any expected rate word
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input bit typed = 1'b0,
                              input rate_reading_type typed_reading = '0);
      rate_reading_type reading;
      bit               produced;
      if (idle_on) begin
         while ($urandom_range(0, 99) < 33) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tdata  <= REQ_DATA_BITS'(s);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      produced = predict_measurement(s, reading);
      if (typed) begin
         produced = 1'b1;
         reading  = typed_reading;
      end
      if (produced) expected_rates.push_back(reading);
      samples_sent++;
   endtask

   // Drop valid, drain all expected words, then let any in-flight word finish
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (expected_rates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB transfer: setup cycle, then access until pready
   task automatic apb_transfer(input logic write, input logic [2:0] index,
                               input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Write a register, update the local copy and read back a mapped one
   task automatic write_register(input logic [2:0] index, input logic [31:0] raw);
      logic [31:0] readback;
      logic [31:0] want;
      bit          known;
      apb_transfer(1'b1, index, raw, readback);
      known = 1'b1;
      want  = '0;
      case (index)
         CSR_PEAK_THRESHOLD: begin
            cfg_threshold = raw[SAMPLE_BITS-1:0];
            want          = 32'(cfg_threshold);
         end
         CSR_RISE_LIMIT: begin
            cfg_rise_limit = raw[COUNT_BITS-1:0];
            want           = 32'(cfg_rise_limit);
         end
         CSR_FALL_LIMIT: begin
            cfg_fall_limit = raw[COUNT_BITS-1:0];
            want           = 32'(cfg_fall_limit);
         end
         CSR_SEARCH_LIMIT: begin
            cfg_search_limit = raw[COUNT_BITS-1:0];
            want             = 32'(cfg_search_limit);
         end
         CSR_SAMPLE_PERIOD: begin
            cfg_period = raw[COUNT_BITS-1:0];
            want       = 32'(cfg_period);
         end
         default: known = 1'b0;
      endcase
      if (known) begin
         apb_transfer(1'b0, index, '0, readback);
         if (readback !== want) begin
            $display("%0t: register %0d readback expected %0d actual %0d",
                     $time, index, want, readback);
            error_count++;
         end
      end
   endtask

   // Random upper bits above a field, which the block must drop
   function automatic logic [31:0] with_junk(input int unsigned field, input int bits);
      return ($urandom() << bits) | field;
   endfunction

   // Pulse-shaped samples: baseline, rising edge, falling tail, some noise and broken pulses
   task automatic drive_waveform(input int unsigned count, input int unsigned max_gap);
      int unsigned first;
      int unsigned rises;
      int unsigned falls;
      int          lvl;
      int          top;
      first = samples_sent;
      while (samples_sent - first < count) begin
         if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 6)) send_sample(SAMPLE_BITS'($urandom()));
         end
         repeat ($urandom_range(0, max_gap)) begin
            if (cfg_threshold == 0) send_sample('0);
            else send_sample(SAMPLE_BITS'($urandom_range(0, int'(cfg_threshold) - 1)));
         end
         rises = int'(cfg_rise_limit) + 1 + $urandom_range(0, 2);
         falls = int'(cfg_fall_limit) + 1 + $urandom_range(0, 2);
         if (rises > 40) rises = $urandom_range(1, 40);
         if (falls > 40) falls = $urandom_range(1, 40);
         if ($urandom_range(0, 9) == 0) rises = $urandom_range(0, rises);
         if ($urandom_range(0, 9) == 0) falls = $urandom_range(0, falls);
         lvl = int'(cfg_threshold);
         repeat (rises) begin
            lvl = lvl + $urandom_range(1, 12);
            if (lvl > 1023) lvl = 1023;
            send_sample(SAMPLE_BITS'(lvl));
         end
         top = lvl;
         repeat (falls) send_sample(SAMPLE_BITS'($urandom_range(int'(cfg_threshold), top)));
      end
   endtask

   // Rate word checker and receiver stalls
   initial begin : rate_checker
      rate_reading_type want;
      int               hold_left;
      hold_left  = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rates.size() == 0) begin
               $display("%0t: unexpected rate word, expected none actual bpm=%0d found=%0b",
                        $time, rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               want = expected_rates.pop_front();
               if (rsp_tdata !== want.bpm) begin
                  $display("%0t: beats_per_minute expected %0d actual %0d",
                           $time, want.bpm, rsp_tdata);
                  error_count++;
               end
               if (rsp_tuser !== want.found) begin
                  $display("%0t: rate_found expected %0b actual %0b",
                           $time, want.found, rsp_tuser);
                  error_count++;
               end
            end
         end
         // Hold off for a long stretch on request, else stall at random while idles are on
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            rsp_tready   <= 1'b0;
         end else begin
            rsp_tready <= idle_on ? ($urandom_range(0, 99) >= 33) : 1'b1;
         end
      end
   end

   // Overall time limit
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Main stimulus
   initial begin : stimulus
      plan_row_type row;
      bit           tame;
      int           phase;
      error_count  = 0;
      samples_sent = 0;
      idle_on      = 1'b1;
      hold_request = 1'b0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;

      cfg_threshold    = THRESHOLD_RESET;
      cfg_rise_limit   = RISE_LIMIT_RESET;
      cfg_fall_limit   = FALL_LIMIT_RESET;
      cfg_search_limit = SEARCH_LIMIT_RESET;
      cfg_period       = PERIOD_RESET;
      meter_second     = 1'b0;
      meter_interval   = '0;
      restart_search();

      directed_plan = '{
         // zero search limit times out after one sample
         '{ROW_WRITE,  CSR_SEARCH_LIMIT,   32'd0,    1'b0, '{8'd0,   1'b0}},
         // close the running search with a first peak so the zero limit takes hold
         '{ROW_SAMPLE, 3'd0,               32'd500,  1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd600,  1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd590,  1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd580,  1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd570,  1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd0,    1'b1, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd1023, 1'b1, '{8'd0,   1'b0}},
         // limits at zero, zero period; new search limit waits for the next search
         '{ROW_WRITE,  CSR_PEAK_THRESHOLD, 32'd0,    1'b0, '{8'd0,   1'b0}},
         '{ROW_WRITE,  CSR_RISE_LIMIT,     32'd0,    1'b0, '{8'd0,   1'b0}},
         '{ROW_WRITE,  CSR_FALL_LIMIT,     32'd0,    1'b0, '{8'd0,   1'b0}},
         '{ROW_WRITE,  CSR_SAMPLE_PERIOD,  32'd0,    1'b0, '{8'd0,   1'b0}},
         '{ROW_WRITE,  CSR_SEARCH_LIMIT,   32'd3,    1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd1023, 1'b1, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd1023, 1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd1023, 1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd1023, 1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd0,    1'b1, '{8'd255, 1'b1}},
         // top threshold and longest period
         '{ROW_WRITE,  CSR_SAMPLE_PERIOD,  32'd255,  1'b0, '{8'd0,   1'b0}},
         '{ROW_WRITE,  CSR_PEAK_THRESHOLD, 32'd1023, 1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd1023, 1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd1023, 1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd1023, 1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd1022, 1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd1023, 1'b0, '{8'd0,   1'b0}},
         // unmapped addresses are ignored
         '{ROW_WRITE,  CSR_SPARE_LOW,      32'hFFFF_FFFF, 1'b0, '{8'd0, 1'b0}},
         '{ROW_WRITE,  CSR_SPARE_TOP,      32'd0,    1'b0, '{8'd0,   1'b0}},
         // back to defaults, two ordinary pulses
         '{ROW_WRITE,  CSR_PEAK_THRESHOLD, 32'd400,  1'b0, '{8'd0,   1'b0}},
         '{ROW_WRITE,  CSR_RISE_LIMIT,     32'd1,    1'b0, '{8'd0,   1'b0}},
         '{ROW_WRITE,  CSR_FALL_LIMIT,     32'd2,    1'b0, '{8'd0,   1'b0}},
         '{ROW_WRITE,  CSR_SEARCH_LIMIT,   32'd255,  1'b0, '{8'd0,   1'b0}},
         '{ROW_WRITE,  CSR_SAMPLE_PERIOD,  32'd20,   1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd500,  1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd600,  1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd700,  1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd650,  1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd600,  1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd550,  1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd500,  1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd600,  1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd700,  1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd650,  1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd600,  1'b0, '{8'd0,   1'b0}},
         '{ROW_SAMPLE, 3'd0,               32'd550,  1'b0, '{8'd0,   1'b0}}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table; register writes only once the block is quiet
      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.kind == ROW_WRITE) begin
            wait_quiet();
            write_register(row.index, row.value);
         end else begin
            send_sample(row.value[SAMPLE_BITS-1:0], row.typed, row.reading);
         end
      end

      // Random phases, each with its own register setting
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_quiet();
         tame = (phase == HOLD_PHASE || phase == SLOW_PHASE);
         case ($urandom_range(0, 5))
            0:       write_register(CSR_PEAK_THRESHOLD, with_junk(0, SAMPLE_BITS));
            1:       write_register(CSR_PEAK_THRESHOLD, with_junk(1023, SAMPLE_BITS));
            default: write_register(CSR_PEAK_THRESHOLD,
                                    with_junk($urandom_range(0, 900), SAMPLE_BITS));
         endcase
         if (phase == PHASE_COUNT - 1) begin
            // limits that no pulse can pass: only timeouts
            write_register(CSR_RISE_LIMIT, with_junk(255, COUNT_BITS));
            write_register(CSR_FALL_LIMIT, with_junk(255, COUNT_BITS));
            write_register(CSR_SEARCH_LIMIT, with_junk($urandom_range(1, 8), COUNT_BITS));
         end else begin
            write_register(CSR_RISE_LIMIT, with_junk((!tame && $urandom_range(0, 7) == 0) ?
                           $urandom_range(0, 255) : $urandom_range(0, 4), COUNT_BITS));
            write_register(CSR_FALL_LIMIT, with_junk((!tame && $urandom_range(0, 7) == 0) ?
                           $urandom_range(0, 255) : $urandom_range(0, 4), COUNT_BITS));
            if (tame) write_register(CSR_SEARCH_LIMIT, with_junk(255, COUNT_BITS));
            else if ($urandom_range(0, 6) == 0)
               write_register(CSR_SEARCH_LIMIT, with_junk($urandom_range(0, 2), COUNT_BITS));
            else
               write_register(CSR_SEARCH_LIMIT, with_junk($urandom_range(10, 255), COUNT_BITS));
         end
         if (phase == SLOW_PHASE)
            write_register(CSR_SAMPLE_PERIOD, with_junk($urandom_range(1, 3), COUNT_BITS));
         else
            write_register(CSR_SAMPLE_PERIOD, with_junk($urandom_range(0, 255), COUNT_BITS));

         idle_on = (phase != STEADY_PHASE);
         if (phase == HOLD_PHASE) hold_request = 1'b1;
         drive_waveform(PHASE_ITEMS, (phase == SLOW_PHASE) ? 200 : 12);
      end
      idle_on = 1'b1;

      // Drain and finish
      wait_quiet();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
